>>> hw/rtl/erq_pkg.sv
// Package for the elevator request queue: sizes, codes and payload structs.
`default_nettype none
package erq_pkg;

  // Sizes
  localparam int NUM_FLOORS  = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int FLOOR_W     = 2;
  localparam int KIND_W      = 2;
  localparam int ENTRY_W     = FLOOR_W + KIND_W;
  localparam int LIGHT_W     = 4;

  // Operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Stop kinds, also used for the car's last direction
  localparam logic [KIND_W-1:0] KIND_UP   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DOWN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CAB  = 2'd2;

  // Request payload
  typedef struct packed {
    logic [1:0]         op;
    logic [FLOOR_W-1:0] req_floor;
    logic [KIND_W-1:0]  req_direction;
    logic [FLOOR_W-1:0] current_floor;
    logic [KIND_W-1:0]  last_direction;
  } erq_in_t;

  // Result payload
  typedef struct packed {
    logic               head_valid;
    logic [FLOOR_W-1:0] head_floor;
    logic [KIND_W-1:0]  head_direction;
    logic [CNT_W-1:0]   queue_length;
    logic [LIGHT_W-1:0] cab_lights;
    logic [LIGHT_W-1:0] up_lights;
    logic [LIGHT_W-1:0] down_lights;
    logic               dropped;
  } erq_out_t;

  // One queued stop
  typedef struct packed {
    logic [FLOOR_W-1:0] floor;
    logic [KIND_W-1:0]  kind;
  } erq_entry_t;

  // Operands of the shared compare unit
  typedef struct packed {
    erq_entry_t entry;
    erq_entry_t req;
    erq_entry_t prev;
    logic       first;
  } erq_cmp_in_t;

  // Verdicts of the shared compare unit
  typedef struct packed {
    logic up_fit;
    logic down_fit;
    logic floor_hit;
  } erq_cmp_out_t;

endpackage
`default_nettype wire

>>> hw/rtl/erq_stop_mem.sv
// Stop memory: one write port, one registered read port.
`default_nettype none
module erq_stop_mem (
  input  wire                     clk,
  input  wire                     wr_en,
  input  wire [erq_pkg::ADDR_W-1:0] wr_addr,
  input  wire erq_pkg::erq_entry_t  wr_data,
  input  wire [erq_pkg::ADDR_W-1:0] rd_addr,
  output erq_pkg::erq_entry_t       rd_q
);
  import erq_pkg::*;

  erq_entry_t mem [QUEUE_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data registered: valid in the cycle after the address
  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/erq_cmp_unit.sv
// Shared compare unit: insertion rules and floor match for one queue entry.
`default_nettype none
module erq_cmp_unit (
  input  wire erq_pkg::erq_cmp_in_t cmp_in,
  output erq_pkg::erq_cmp_out_t     cmp_out
);
  import erq_pkg::*;

  logic same_floor;
  logic up_kind;
  logic down_kind;

  assign same_floor = (cmp_in.prev.floor == cmp_in.req.floor);
  assign up_kind    = (cmp_in.req.kind == KIND_UP) || (cmp_in.req.kind == KIND_CAB);
  assign down_kind  = (cmp_in.req.kind == KIND_DOWN) || (cmp_in.req.kind == KIND_CAB);

  // Up rule: request lies between previous stop and this entry, going up
  assign cmp_out.up_fit = (cmp_in.entry.floor >= cmp_in.req.floor) &&
                          (cmp_in.req.floor >= cmp_in.prev.floor) &&
                          (!same_floor || ((cmp_in.prev.kind == KIND_DOWN) && cmp_in.first)) &&
                          up_kind;

  // Down rule: mirror image
  assign cmp_out.down_fit = (cmp_in.entry.floor <= cmp_in.req.floor) &&
                            (cmp_in.req.floor <= cmp_in.prev.floor) &&
                            (!same_floor || ((cmp_in.prev.kind == KIND_UP) && cmp_in.first)) &&
                            down_kind;

  // Remove looks for the floor only
  assign cmp_out.floor_hit = (cmp_in.entry.floor == cmp_in.req.floor);

endmodule
`default_nettype wire

>>> hw/rtl/elevator_request_queue_unit.sv
// Top level of the elevator request queue: sequencer, presence lights, result register.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. It
//   carries an op (add, remove, clear), a floor, a kind and the car's
//   current floor and last direction. busy stays high while the request is
//   worked on; exactly one result follows per request, on out_item for a
//   single cycle with out_valid high, in the first cycle with busy low again.
//   The receiver cannot stall; it must take the result in that cycle.
// Sequence:
//   The queue is walked one entry per cycle through one compare unit and a
//   single-read-port stop memory. An add placed ahead of an entry runs
//   scan, prep, moves, insert and head read; an append runs scan (none on an
//   empty queue), insert and head read; a remove runs scan, then prep and
//   moves for an inner stop, then head read; clear, ignored, duplicate and
//   dropped requests go straight to the head read. The next request can be
//   taken at the edge that ends the result cycle.
// Reset:
//   Synchronous, active low. The queue comes up empty with all lights off;
//   stop memory needs no clearing since entries past the count are never used.
`default_nettype none
module elevator_request_queue_unit (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire erq_pkg::erq_in_t in_item,
  output logic                 out_valid,
  output erq_pkg::erq_out_t    out_item
);
  import erq_pkg::*;

  // Sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_PREP    = 3'd2;
  localparam logic [2:0] ST_MOVE_UP = 3'd3;
  localparam logic [2:0] ST_MOVE_DN = 3'd4;
  localparam logic [2:0] ST_INS     = 3'd5;
  localparam logic [2:0] ST_HEAD_RD = 3'd6;
  localparam logic [2:0] ST_HEAD_Q  = 3'd7;

  logic [2:0]         state_r, state_nxt;
  erq_in_t            req_r, req_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   src_r, src_nxt;
  erq_entry_t         prev_r, prev_nxt;
  logic               drop_r, drop_nxt;
  logic [LIGHT_W-1:0] up_r, up_nxt;
  logic [LIGHT_W-1:0] dn_r, dn_nxt;
  logic [LIGHT_W-1:0] cab_r, cab_nxt;
  logic               out_valid_r, out_valid_nxt;
  erq_out_t           out_r, out_nxt;

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  erq_entry_t         mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  erq_entry_t         mem_q;

  erq_cmp_in_t        cmp_in;
  erq_cmp_out_t       cmp_out;

  logic               accept;
  logic [LIGHT_W-1:0] req_bit;
  logic [LIGHT_W-1:0] ent_bit;
  logic               dup;
  logic               bad_req;
  logic               last_idx;
  erq_entry_t         new_entry;

  erq_stop_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_q    (mem_q)
  );

  erq_cmp_unit u_cmp (
    .cmp_in  (cmp_in),
    .cmp_out (cmp_out)
  );

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Compare operands: entry under the walk against the request
  assign new_entry    = '{floor: req_r.req_floor, kind: req_r.req_direction};
  assign cmp_in.entry = mem_q;
  assign cmp_in.req   = new_entry;
  assign cmp_in.prev  = prev_r;
  assign cmp_in.first = (idx_r == '0);

  assign req_bit  = LIGHT_W'(1) << in_item.req_floor;
  assign ent_bit  = LIGHT_W'(1) << mem_q.floor;
  assign last_idx = ((idx_r + CNT_W'(1)) == count_r);

  // Duplicate check straight from the presence lights
  always_comb begin
    unique case (in_item.req_direction)
      KIND_UP:   dup = |(up_r & req_bit);
      KIND_DOWN: dup = |(dn_r & req_bit);
      KIND_CAB:  dup = |(cab_r & req_bit);
      default:   dup = 1'b0;
    endcase
  end

  assign bad_req = (in_item.req_direction > KIND_CAB) ||
                   (int'(in_item.req_floor) >= NUM_FLOORS);

  // Read address for the next cycle's entry
  always_comb begin
    unique case (state_r)
      ST_SCAN:    mem_raddr = ADDR_W'(idx_r + CNT_W'(1));
      ST_PREP:    mem_raddr = src_r[ADDR_W-1:0];
      ST_MOVE_UP: mem_raddr = ADDR_W'(src_r - CNT_W'(1));
      ST_MOVE_DN: mem_raddr = ADDR_W'(src_r + CNT_W'(1));
      default:    mem_raddr = '0;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    src_nxt       = src_r;
    prev_nxt      = prev_r;
    drop_nxt      = drop_r;
    up_nxt        = up_r;
    dn_nxt        = dn_r;
    cab_nxt       = cab_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = mem_q;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt       = in_item;
          idx_nxt       = '0;
          prev_nxt      = '{floor: in_item.current_floor, kind: in_item.last_direction};
          drop_nxt      = 1'b0;
          state_nxt     = ST_HEAD_RD;
          unique case (in_item.op)
            OP_ADD: begin
              if (bad_req || dup) begin
                state_nxt = ST_HEAD_RD;
              end else if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                drop_nxt  = 1'b1;
              end else if (count_r == '0) begin
                pos_nxt   = '0;
                state_nxt = ST_INS;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            OP_REMOVE: begin
              if (count_r != '0) begin
                state_nxt = ST_SCAN;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
              up_nxt    = '0;
              dn_nxt    = '0;
              cab_nxt   = '0;
            end
            default: state_nxt = ST_HEAD_RD;
          endcase
        end
      end

      // Walk the queue one entry per cycle
      ST_SCAN: begin
        if (req_r.op == OP_ADD) begin
          if (cmp_out.up_fit || cmp_out.down_fit) begin
            pos_nxt   = idx_r;
            src_nxt   = count_r - CNT_W'(1);
            state_nxt = ST_PREP;
          end else if (last_idx) begin
            pos_nxt   = count_r;
            state_nxt = ST_INS;
          end else begin
            prev_nxt = mem_q;
            idx_nxt  = idx_r + CNT_W'(1);
          end
        end else begin
          if (cmp_out.floor_hit) begin
            count_nxt = count_r - CNT_W'(1);
            unique case (mem_q.kind)
              KIND_UP:   up_nxt  = up_r & ~ent_bit;
              KIND_DOWN: dn_nxt  = dn_r & ~ent_bit;
              KIND_CAB:  cab_nxt = cab_r & ~ent_bit;
              default:   up_nxt  = up_r;
            endcase
            src_nxt   = idx_r + CNT_W'(1);
            state_nxt = last_idx ? ST_HEAD_RD : ST_PREP;
          end else if (last_idx) begin
            state_nxt = ST_HEAD_RD;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end

      // First read of a move
      ST_PREP: begin
        state_nxt = (req_r.op == OP_ADD) ? ST_MOVE_UP : ST_MOVE_DN;
      end

      // Open a slot: entry src moves to src+1, walking down
      ST_MOVE_UP: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(src_r + CNT_W'(1));
        if (src_r == pos_r) begin
          state_nxt = ST_INS;
        end else begin
          src_nxt = src_r - CNT_W'(1);
        end
      end

      // Close a gap: entry src moves to src-1, walking up
      ST_MOVE_DN: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(src_r - CNT_W'(1));
        if (src_r == count_r) begin
          state_nxt = ST_HEAD_RD;
        end else begin
          src_nxt = src_r + CNT_W'(1);
        end
      end

      // Place the new stop
      ST_INS: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r[ADDR_W-1:0];
        mem_wdata = new_entry;
        count_nxt = count_r + CNT_W'(1);
        unique case (req_r.req_direction)
          KIND_UP:   up_nxt  = up_r | (LIGHT_W'(1) << req_r.req_floor);
          KIND_DOWN: dn_nxt  = dn_r | (LIGHT_W'(1) << req_r.req_floor);
          default:   cab_nxt = cab_r | (LIGHT_W'(1) << req_r.req_floor);
        endcase
        state_nxt = ST_HEAD_RD;
      end

      ST_HEAD_RD: begin
        state_nxt = ST_HEAD_Q;
      end

      // Head entry is on the read port: build the result
      ST_HEAD_Q: begin
        out_valid_nxt          = 1'b1;
        out_nxt.head_valid     = (count_r != '0);
        out_nxt.head_floor     = (count_r != '0) ? mem_q.floor : '0;
        out_nxt.head_direction = (count_r != '0) ? mem_q.kind : '0;
        out_nxt.queue_length   = count_r;
        out_nxt.cab_lights     = cab_r;
        out_nxt.up_lights      = up_r;
        out_nxt.down_lights    = dn_r;
        out_nxt.dropped        = drop_r;
        state_nxt              = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      up_r        <= '0;
      dn_r        <= '0;
      cab_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      up_r        <= up_nxt;
      dn_r        <= dn_nxt;
      cab_r       <= cab_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    idx_r  <= idx_nxt;
    pos_r  <= pos_nxt;
    src_r  <= src_nxt;
    prev_r <= prev_nxt;
    drop_r <= drop_nxt;
    out_r  <= out_nxt;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("request taken but block not busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && (out_item.queue_length == count_r))
    else $error("result not consistent with queue state");

  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.head_valid == (out_item.queue_length != '0)))
    else $error("head valid disagrees with queue length");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.dropped) |-> (out_item.queue_length == CNT_W'(QUEUE_DEPTH)))
    else $error("drop reported with room left");

endmodule
`default_nettype wire

>>> test/tb_elevator_request_queue_unit.sv
// Testbench for elevator_request_queue_unit: directed table and random requests against a predictor.
`timescale 1ns / 1ps
module tb_elevator_request_queue_unit;
  import erq_pkg::*;

  // Codes outside the defined range, used to hit the ignore paths
  localparam logic [1:0]        OP_UNKNOWN = 2'd3;
  localparam logic [KIND_W-1:0] KIND_BAD   = 2'd3;
  localparam int NUM_RANDOM  = 1500;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 40;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  erq_in_t  in_item;
  logic     out_valid;
  erq_out_t out_item;

  elevator_request_queue_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // Directed table row: request plus an optional typed-in status
  typedef struct {
    erq_in_t  req;
    bit       has_status;
    erq_out_t status;
  } table_row_t;

  table_row_t  stim_table[$];
  erq_out_t    pending_status[$];
  erq_entry_t  shadow_stops[QUEUE_DEPTH];
  int          shadow_count;
  int          fail_count;
  int          cycle_count;
  bit          row_has_status;
  erq_out_t    row_status;

  function automatic erq_in_t make_req(logic [1:0] op, logic [1:0] fl, logic [1:0] kd,
                                       logic [1:0] cur, logic [1:0] last);
    erq_in_t r;
    r.op             = op;
    r.req_floor      = fl;
    r.req_direction  = kd;
    r.current_floor  = cur;
    r.last_direction = last;
    return r;
  endfunction

  function automatic erq_out_t make_status(bit hv, logic [1:0] hf, logic [1:0] hd, int len,
                                           logic [3:0] cab, logic [3:0] up, logic [3:0] down,
                                           bit drop);
    erq_out_t s;
    s.head_valid     = hv;
    s.head_floor     = hf;
    s.head_direction = hd;
    s.queue_length   = CNT_W'(len);
    s.cab_lights     = cab;
    s.up_lights      = up;
    s.down_lights    = down;
    s.dropped        = drop;
    return s;
  endfunction

  task automatic add_row(erq_in_t r, bit has, erq_out_t s);
    table_row_t row;
    row.req        = r;
    row.has_status = has;
    row.status     = s;
    stim_table.push_back(row);
  endtask

  // Shadow queue update and status computation for one request
  function automatic erq_out_t apply_request(erq_in_t r);
    erq_out_t   s;
    erq_entry_t prev;
    erq_entry_t e;
    bit         dup;
    bit         placed;
    int         pos;
    s = '0;
    case (r.op)
      OP_ADD: begin
        if (r.req_direction <= KIND_CAB && r.req_floor < NUM_FLOORS) begin
          dup = 1'b0;
          for (int i = 0; i < shadow_count; i++)
            if (shadow_stops[i].floor == r.req_floor && shadow_stops[i].kind == r.req_direction)
              dup = 1'b1;
          if (!dup && shadow_count >= QUEUE_DEPTH) begin
            s.dropped = 1'b1;
          end else if (!dup) begin
            pos        = shadow_count;
            placed     = 1'b0;
            prev.floor = r.current_floor;
            prev.kind  = r.last_direction;
            for (int i = 0; i < shadow_count; i++) begin
              if (!placed) begin
                e = shadow_stops[i];
                // up rule: request lies between previous stop and this entry going up
                if (e.floor >= r.req_floor && r.req_floor >= prev.floor &&
                    (prev.floor != r.req_floor || (prev.kind == KIND_DOWN && i == 0)) &&
                    (r.req_direction == KIND_UP || r.req_direction == KIND_CAB)) begin
                  pos    = i;
                  placed = 1'b1;
                // down rule: same idea going down
                end else if (e.floor <= r.req_floor && r.req_floor <= prev.floor &&
                    (prev.floor != r.req_floor || (prev.kind == KIND_UP && i == 0)) &&
                    (r.req_direction == KIND_DOWN || r.req_direction == KIND_CAB)) begin
                  pos    = i;
                  placed = 1'b1;
                end else begin
                  prev = e;
                end
              end
            end
            for (int j = shadow_count; j > pos; j--)
              shadow_stops[j] = shadow_stops[j-1];
            shadow_stops[pos].floor = r.req_floor;
            shadow_stops[pos].kind  = r.req_direction;
            shadow_count++;
          end
        end
      end
      OP_REMOVE: begin
        placed = 1'b0;
        for (int i = 0; i < shadow_count; i++) begin
          if (!placed && shadow_stops[i].floor == r.req_floor) begin
            for (int j = i; j + 1 < shadow_count; j++)
              shadow_stops[j] = shadow_stops[j+1];
            shadow_count--;
            placed = 1'b1;
          end
        end
      end
      OP_CLEAR: shadow_count = 0;
      default: ;
    endcase

    // Lights and head from the updated queue
    for (int i = 0; i < shadow_count; i++) begin
      case (shadow_stops[i].kind)
        KIND_CAB:  s.cab_lights[shadow_stops[i].floor]  = 1'b1;
        KIND_UP:   s.up_lights[shadow_stops[i].floor]   = 1'b1;
        KIND_DOWN: s.down_lights[shadow_stops[i].floor] = 1'b1;
        default: ;
      endcase
    end
    s.head_valid   = (shadow_count > 0);
    if (shadow_count > 0) begin
      s.head_floor     = shadow_stops[0].floor;
      s.head_direction = shadow_stops[0].kind;
    end
    s.queue_length = CNT_W'(shadow_count);
    return s;
  endfunction

  task automatic cmp_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Monitor: record accepted requests, check each strobed status
  always @(posedge clk) begin
    erq_out_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d statuses outstanding", $time, pending_status.size());
      $display("** elevator_request_queue_unit: FAILED **");
      $finish;
    end else if (rst_n) begin
      if (out_valid) begin
        if (pending_status.size() == 0) begin
          $display("%0t: unexpected status, actual %h", $time, out_item);
          fail_count++;
        end else begin
          want = pending_status.pop_front();
          cmp_field("head_valid", 8'(want.head_valid), 8'(out_item.head_valid));
          cmp_field("head_floor", 8'(want.head_floor), 8'(out_item.head_floor));
          cmp_field("head_direction", 8'(want.head_direction), 8'(out_item.head_direction));
          cmp_field("queue_length", 8'(want.queue_length), 8'(out_item.queue_length));
          cmp_field("cab_lights", 8'(want.cab_lights), 8'(out_item.cab_lights));
          cmp_field("up_lights", 8'(want.up_lights), 8'(out_item.up_lights));
          cmp_field("down_lights", 8'(want.down_lights), 8'(out_item.down_lights));
          cmp_field("dropped", 8'(want.dropped), 8'(out_item.dropped));
        end
      end
      if (start && !busy) begin
        want = apply_request(in_item);
        if (row_has_status) want = row_status;
        pending_status.push_back(want);
      end
    end
  end

  // Present one request after a gap; returns at the falling edge after acceptance
  task automatic issue(erq_in_t r, bit has, erq_out_t s, int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item        = r;
    row_has_status = has;
    row_status     = s;
    start          = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  function automatic int pick_gap(int n);
    int roll;
    roll = $urandom_range(0, 99);
    if ((n % 300) < 60) return 0;    // stretches with no idling
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Mostly valid adds with random content; removes, clears and junk mixed in
  function automatic erq_in_t random_request();
    erq_in_t r;
    int      roll;
    roll = $urandom_range(0, 99);
    r.op = (roll < 68) ? OP_ADD : (roll < 88) ? OP_REMOVE : (roll < 93) ? OP_CLEAR : OP_UNKNOWN;
    r.req_floor      = FLOOR_W'($urandom_range(0, 3));
    r.req_direction  = ($urandom_range(0, 99) < 6) ? KIND_BAD : KIND_W'($urandom_range(0, 2));
    r.current_floor  = FLOOR_W'($urandom_range(0, 3));
    r.last_direction = ($urandom_range(0, 99) < 10) ? KIND_BAD : KIND_W'($urandom_range(0, 2));
    return r;
  endfunction

  initial begin
    erq_out_t empty_status;
    erq_out_t none;
    clk            = 1'b0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_item        = '0;
    row_has_status = 1'b0;
    row_status     = '0;
    shadow_count   = 0;
    fail_count     = 0;
    cycle_count    = 0;
    empty_status   = make_status(0, 0, KIND_UP, 0, 4'b0000, 4'b0000, 4'b0000, 0);
    none           = '0;

    // Directed table: empty-queue ops, ignored requests, same-floor cases, removes
    add_row(make_req(OP_CLEAR, 0, KIND_UP, 0, KIND_UP), 1, empty_status);
    add_row(make_req(OP_REMOVE, 3, KIND_UP, 0, KIND_UP), 1, empty_status);
    add_row(make_req(OP_UNKNOWN, 2, KIND_UP, 1, KIND_UP), 1, empty_status);
    add_row(make_req(OP_ADD, 2, KIND_BAD, 0, KIND_UP), 1, empty_status);
    add_row(make_req(OP_ADD, 2, KIND_CAB, 0, KIND_UP), 1,
            make_status(1, 2, KIND_CAB, 1, 4'b0100, 4'b0000, 4'b0000, 0));
    add_row(make_req(OP_ADD, 2, KIND_CAB, 3, KIND_DOWN), 1,
            make_status(1, 2, KIND_CAB, 1, 4'b0100, 4'b0000, 4'b0000, 0));
    add_row(make_req(OP_ADD, 3, KIND_UP, 0, KIND_UP), 0, none);
    add_row(make_req(OP_ADD, 0, KIND_DOWN, 3, KIND_DOWN), 0, none);
    add_row(make_req(OP_ADD, 1, KIND_UP, 1, KIND_DOWN), 0, none);
    add_row(make_req(OP_ADD, 1, KIND_DOWN, 1, KIND_UP), 0, none);
    add_row(make_req(OP_ADD, 2, KIND_UP, 2, KIND_BAD), 0, none);
    add_row(make_req(OP_ADD, 0, KIND_CAB, 3, KIND_CAB), 0, none);
    add_row(make_req(OP_ADD, 3, KIND_DOWN, 0, KIND_UP), 0, none);
    add_row(make_req(OP_REMOVE, 1, KIND_UP, 0, KIND_UP), 0, none);
    add_row(make_req(OP_REMOVE, 0, KIND_UP, 0, KIND_UP), 0, none);
    add_row(make_req(OP_REMOVE, 2, KIND_BAD, 3, KIND_BAD), 0, none);
    add_row(make_req(OP_CLEAR, 3, KIND_BAD, 3, KIND_BAD), 1, empty_status);
    add_row(make_req(OP_ADD, 0, KIND_UP, 0, KIND_DOWN), 1,
            make_status(1, 0, KIND_UP, 1, 4'b0000, 4'b0001, 4'b0000, 0));
    add_row(make_req(OP_ADD, 3, KIND_CAB, 3, KIND_UP), 0, none);
    add_row(make_req(OP_ADD, 3, KIND_BAD, 3, KIND_BAD), 0, none);
    add_row(make_req(OP_CLEAR, 0, KIND_UP, 0, KIND_UP), 1, empty_status);

    // Hold reset, then release it
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_table[i])
      issue(stim_table[i].req, stim_table[i].has_status, stim_table[i].status,
            pick_gap(i + 100));

    for (int n = 0; n < NUM_RANDOM; n++) begin
      // hold off once until the block has reported everything
      if (n == NUM_RANDOM / 2) begin
        start = 1'b0;
        while (pending_status.size() != 0) @(negedge clk);
        @(negedge clk);
      end
      issue(random_request(), 1'b0, none, pick_gap(n));
    end
    start = 1'b0;

    // Drain, then watch for stray statuses
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0)
      $display("** elevator_request_queue_unit: PASSED **");
    else
      $display("** elevator_request_queue_unit: FAILED **");
    $finish;
  end

endmodule
